### rtl/rqms_pkg.sv
// Package for the ready queue with least-key select.
// Holds the transaction payload types, the stored entry type and the function codes.
// No dependencies.
package rqms_pkg;

    // Function codes carried in the func field.
    localparam logic [2:0] FN_PUSH     = 3'd0;
    localparam logic [2:0] FN_POP_FIFO = 3'd1;
    localparam logic [2:0] FN_SEL_PRIO = 3'd2;
    localparam logic [2:0] FN_SEL_REM  = 3'd3;
    localparam logic [2:0] FN_TICK     = 3'd4;

    // Waiting count saturates at this value.
    localparam logic [15:0] WAIT_MAX = 16'hFFFF;

    // Input transaction.
    typedef struct packed {
        logic [2:0] func;
        logic [3:0] process_id;
        logic [7:0] priority_key;
        logic [7:0] remaining_cpu;
        logic       remove;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic [3:0]  chosen_id;
        logic [15:0] chosen_wait;
        logic        fault;
        logic [4:0]  queue_count;
    } out_t;

    // One queue entry as held in the store.
    typedef struct packed {
        logic [3:0]  id;
        logic [7:0]  prio;
        logic [7:0]  rem;
        logic [15:0] wait_cnt;
    } entry_t;

endpackage

### rtl/rqms_store.sv
// Entry store of the ready queue: one write port and one registered read port.
// Depends on rqms_pkg for the entry type.
module rqms_store #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  rqms_pkg::entry_t              wdata,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output rqms_pkg::entry_t              rdata
);
    import rqms_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write and registered read; both ports work in the same cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ready_queue_min_select.sv
// Ready queue of a CPU scheduler with FIFO pop, least-key select and ageing.
// Push, fault or unused code go straight to the result; a select scans every queued entry
// through the single read port, a FIFO pop reads only the head, and a removal then shifts the
// entries behind the chosen one down one place to compact; a tick ages every entry in place.
// One transaction at a time; s_ready returns the cycle after the result is loaded, and a
// waiting result stalls it. Synchronous active-low reset empties the queue and drops any result.
module ready_queue_min_select #(
    parameter int DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rqms_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rqms_pkg::out_t m_data
);
    import rqms_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MOVE = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       func_reg, func_next;
    logic             remove_reg, remove_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] ppos_reg, ppos_next;
    logic [7:0]       best_key_reg, best_key_next;
    logic [IDX_W-1:0] best_pos_reg, best_pos_next;
    logic [3:0]       best_id_reg, best_id_next;
    logic [15:0]      best_wait_reg, best_wait_next;
    logic             fault_reg, fault_next;
    logic             choice_reg, choice_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
    entry_t           rdata;

    logic [CNT_W-1:0] scan_limit;
    logic [7:0]       rd_key;

    rqms_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // A FIFO pop looks only at the head; the selects scan the whole queue.
    assign scan_limit = (func_reg == FN_POP_FIFO) ? CNT_W'(1) : cnt_reg;
    assign rd_key     = (func_reg == FN_SEL_PRIO) ? rdata.prio : rdata.rem;
    assign raddr      = idx_reg[IDX_W-1:0];

    // Sequencer: while scanning or moving, one store read issued per cycle, its data consumed in the next cycle.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        remove_next    = remove_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        ppos_next      = ppos_reg;
        best_key_next  = best_key_reg;
        best_pos_next  = best_pos_reg;
        best_id_next   = best_id_reg;
        best_wait_next = best_wait_reg;
        fault_next     = fault_reg;
        choice_next    = choice_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;

        // The result register empties when the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next   = s_data.func;
                    remove_next = s_data.remove;
                    fault_next  = 1'b0;
                    choice_next = 1'b0;
                    idx_next    = '0;
                    case (s_data.func)
                        FN_PUSH: begin
                            if (cnt_reg == CNT_W'(DEPTH)) begin
                                fault_next = 1'b1;
                            end else begin
                                we             = 1'b1;
                                waddr          = cnt_reg[IDX_W-1:0];
                                wdata.id       = s_data.process_id;
                                wdata.prio     = s_data.priority_key;
                                wdata.rem      = s_data.remaining_cpu;
                                wdata.wait_cnt = '0;
                                cnt_next       = cnt_reg + CNT_W'(1);
                            end
                            state_next = ST_DONE;
                        end
                        FN_POP_FIFO, FN_SEL_PRIO, FN_SEL_REM: begin
                            if (cnt_reg == '0) begin
                                fault_next = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                choice_next = 1'b1;
                                state_next  = ST_SCAN;
                            end
                        end
                        FN_TICK: begin
                            state_next = ST_MOVE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Issue the next read while entries remain.
                if (idx_reg < scan_limit) begin
                    pend_next = 1'b1;
                    ppos_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
                // Keep the first entry with the strictly least key.
                if (pend_reg) begin
                    if (ppos_reg == '0 || rd_key < best_key_reg) begin
                        best_key_next  = rd_key;
                        best_pos_next  = ppos_reg;
                        best_id_next   = rdata.id;
                        best_wait_next = rdata.wait_cnt;
                    end
                end
                if (idx_reg >= scan_limit && !pend_reg) begin
                    if (func_reg != FN_POP_FIFO && !remove_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = CNT_W'(best_pos_reg) + CNT_W'(1);
                        state_next = ST_MOVE;
                    end
                end
            end

            ST_MOVE: begin
                // Stream entries through: age them in place, or shift them down one.
                if (idx_reg < cnt_reg) begin
                    pend_next = 1'b1;
                    ppos_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    we    = 1'b1;
                    wdata = rdata;
                    if (func_reg == FN_TICK) begin
                        waddr = ppos_reg;
                        if (rdata.wait_cnt != WAIT_MAX) begin
                            wdata.wait_cnt = rdata.wait_cnt + 16'd1;
                        end
                    end else begin
                        waddr = ppos_reg - IDX_W'(1);
                    end
                end
                if (idx_reg >= cnt_reg && !pend_reg) begin
                    if (func_reg != FN_TICK) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.chosen_id   = choice_reg ? best_id_reg : 4'd0;
                    m_data_next.chosen_wait = choice_reg ? best_wait_reg : 16'd0;
                    m_data_next.fault       = fault_reg;
                    m_data_next.queue_count = 5'(cnt_reg);
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg      <= func_next;
        remove_reg    <= remove_next;
        idx_reg       <= idx_next;
        ppos_reg      <= ppos_next;
        best_key_reg  <= best_key_next;
        best_pos_reg  <= best_pos_next;
        best_id_reg   <= best_id_next;
        best_wait_reg <= best_wait_next;
        fault_reg     <= fault_next;
        choice_reg    <= choice_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### verif/ready_queue_min_select_tb.sv
// Self-checking testbench for the ready queue with FIFO pop, least-key select and ageing.
// Depends on rqms_pkg and ready_queue_min_select. It runs a directed table and then
// random traffic, and predicts each result with a behavioural queue.
module ready_queue_min_select_tb;
    import rqms_pkg::*;

    localparam int QDEPTH           = 16;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 345;
    localparam int SETTLE_CYCLES    = 60;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct {
        in_t  op;
        int   reps;
        bit   typed;
        out_t want;
    } plan_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Behavioural copy of the queue and the results still owed by the block.
    entry_t    ready_q[$];
    out_t      owed_results[$];
    plan_row_t directed_plan[$];

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    bit filling        = 1'b1;

    ready_queue_min_select #(
        .DEPTH(QDEPTH)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #10 aclk = ~aclk;

    // Applies one operation to the behavioural queue and returns the result it owes.
    function automatic out_t schedule_step(input in_t op);
        out_t   res;
        entry_t fresh;
        int     best;
        res  = '0;
        best = 0;
        case (op.func)
            FN_PUSH: begin
                if (ready_q.size() >= QDEPTH) begin
                    res.fault = 1'b1;
                end else begin
                    fresh.id       = op.process_id;
                    fresh.prio     = op.priority_key;
                    fresh.rem      = op.remaining_cpu;
                    fresh.wait_cnt = '0;
                    ready_q.push_back(fresh);
                end
            end
            FN_POP_FIFO, FN_SEL_PRIO, FN_SEL_REM: begin
                if (ready_q.size() == 0) begin
                    res.fault = 1'b1;
                end else begin
                    // Strictly less keeps the earliest entry on a tie.
                    if (op.func != FN_POP_FIFO) begin
                        for (int i = 1; i < ready_q.size(); i++) begin
                            if (op.func == FN_SEL_PRIO ? ready_q[i].prio < ready_q[best].prio
                                                       : ready_q[i].rem < ready_q[best].rem)
                                best = i;
                        end
                    end
                    res.chosen_id   = ready_q[best].id;
                    res.chosen_wait = ready_q[best].wait_cnt;
                    if (op.func == FN_POP_FIFO || op.remove)
                        ready_q.delete(best);
                end
            end
            FN_TICK: begin
                foreach (ready_q[i]) begin
                    if (ready_q[i].wait_cnt != WAIT_MAX)
                        ready_q[i].wait_cnt = ready_q[i].wait_cnt + 16'd1;
                end
            end
            default: ;
        endcase
        res.queue_count = 5'(ready_q.size());
        return res;
    endfunction

    function automatic void add_row(input logic [2:0] func, input int pid, input int prio,
                                    input int rem, input bit rm, input int reps, input bit typed,
                                    input int w_id, input int w_wait, input bit w_fault,
                                    input int w_cnt);
        plan_row_t row;
        row.op.func             = func;
        row.op.process_id       = 4'(pid);
        row.op.priority_key     = 8'(prio);
        row.op.remaining_cpu    = 8'(rem);
        row.op.remove           = rm;
        row.reps                = reps;
        row.typed               = typed;
        row.want.chosen_id      = 4'(w_id);
        row.want.chosen_wait    = 16'(w_wait);
        row.want.fault          = w_fault;
        row.want.queue_count    = 5'(w_cnt);
        directed_plan.push_back(row);
    endfunction

    // Random operation, steered to fill the queue and drain it again with random content.
    function automatic in_t random_op();
        in_t op;
        int  pick;
        op.process_id    = 4'($urandom);
        op.priority_key  = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        op.remaining_cpu = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        op.remove        = 1'($urandom);
        if (ready_q.size() == QDEPTH && $urandom_range(2) == 0)
            filling = 1'b0;
        else if (ready_q.size() == 0 && $urandom_range(2) == 0)
            filling = 1'b1;
        else if ($urandom_range(39) == 0)
            filling = ~filling;
        pick = $urandom_range(99);
        if (pick < 3)
            op.func = FN_TICK + 3'($urandom_range(1, 3));
        else if (pick < 13)
            op.func = FN_TICK;
        else if (filling ? pick < 63 : pick < 30)
            op.func = FN_PUSH;
        else
            op.func = 3'($urandom_range(FN_POP_FIFO, FN_SEL_REM));
        return op;
    endfunction

    // Offers one transaction, waits for it to be taken and records what it owes.
    task automatic offer(input in_t op, input bit typed, input out_t want);
        out_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = schedule_step(op);
        owed_results.push_back(typed ? want : predicted);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("Mismatch on result %0d: %s", results_seen, msg);
    endtask

    // Receiver: random back-pressure, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result checking against the oldest owed result, and the quiet-cycle count.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with no transaction waiting for it");
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.chosen_id !== want.chosen_id)
                        report_mismatch($sformatf("chosen_id %0d, expected %0d",
                                                  m_data.chosen_id, want.chosen_id));
                    if (m_data.chosen_wait !== want.chosen_wait)
                        report_mismatch($sformatf("chosen_wait %0d, expected %0d",
                                                  m_data.chosen_wait, want.chosen_wait));
                    if (m_data.fault !== want.fault)
                        report_mismatch($sformatf("fault %0b, expected %0b",
                                                  m_data.fault, want.fault));
                    if (m_data.queue_count !== want.queue_count)
                        report_mismatch($sformatf("queue_count %0d, expected %0d",
                                                  m_data.queue_count, want.queue_count));
                end
                results_seen++;
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, three random phases, then drain.
    initial begin
        out_t none;
        none = '0;

        // Empty queue: every removal faults, tick and unused codes do nothing.
        add_row(FN_POP_FIFO, 0, 0, 0, 1'b0, 1, 1'b1, 0, 0, 1'b1, 0);
        add_row(FN_SEL_PRIO, 0, 0, 0, 1'b1, 1, 1'b1, 0, 0, 1'b1, 0);
        add_row(FN_SEL_REM, 0, 0, 0, 1'b0, 1, 1'b1, 0, 0, 1'b1, 0);
        add_row(FN_TICK, 0, 0, 0, 1'b0, 1, 1'b1, 0, 0, 1'b0, 0);
        add_row(FN_TICK + 3'd1, 0, 0, 0, 1'b0, 1, 1'b1, 0, 0, 1'b0, 0);
        // Extreme keys with ties on both priority and remaining time.
        add_row(FN_PUSH, 15, 255, 0, 1'b0, 1, 1'b1, 0, 0, 1'b0, 1);
        add_row(FN_PUSH, 0, 0, 255, 1'b0, 1, 1'b1, 0, 0, 1'b0, 2);
        add_row(FN_PUSH, 5, 0, 0, 1'b0, 1, 1'b1, 0, 0, 1'b0, 3);
        add_row(FN_TICK, 0, 0, 0, 1'b0, 1, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_SEL_PRIO, 0, 0, 0, 1'b0, 1, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_SEL_REM, 0, 0, 0, 1'b1, 1, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_TICK + 3'd2, 15, 255, 255, 1'b1, 1, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_TICK + 3'd3, 15, 255, 255, 1'b1, 1, 1'b0, 0, 0, 1'b0, 0);
        // Fill to the top, then a push on a full queue.
        add_row(FN_PUSH, 10, 8'h5A, 8'hA5, 1'b0, 14, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_PUSH, 3, 1, 1, 1'b1, 1, 1'b1, 0, 0, 1'b1, 16);
        add_row(FN_SEL_PRIO, 0, 0, 0, 1'b1, 1, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_POP_FIFO, 0, 0, 0, 1'b0, 15, 1'b0, 0, 0, 1'b0, 0);
        // A single entry aged by a run of ticks, then peeked and popped.
        add_row(FN_PUSH, 12, 8'h80, 8'h01, 1'b0, 1, 1'b1, 0, 0, 1'b0, 1);
        add_row(FN_TICK, 0, 0, 0, 1'b0, 20, 1'b0, 0, 0, 1'b0, 0);
        add_row(FN_SEL_REM, 0, 0, 0, 1'b0, 1, 1'b1, 12, 20, 1'b0, 1);
        add_row(FN_POP_FIFO, 0, 0, 0, 1'b0, 1, 1'b1, 12, 20, 1'b0, 0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[r]) begin
            repeat (directed_plan[r].reps)
                offer(directed_plan[r].op, directed_plan[r].typed, directed_plan[r].want);
        end

        // Random phases; the last fifth of every hundred runs without idling, and all of the third phase does.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 2)
                hold_left = HOLD_CYCLES;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 100 >= 80 || phase == 2) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end else begin
                    tx_idle_pct = (phase == 0) ? 30 : 60;
                    rx_idle_pct = (phase == 0) ? 60 : 30;
                end
                offer(random_op(), 1'b0, none);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
